### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a property on the rising edge of clk, muted while rst_n is low
`define FSCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks that a condition never holds
`define FSCR_NEVER(lbl, cond, msg) \
  `FSCR_ASSERT(lbl, !(cond), msg)

`endif

### rtl/fscr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fscr_pkg;

  // framing bytes
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_EOT = 8'h04;

  // one-byte command codes
  localparam logic [7:0] CMD_HELLO     = 8'h48; // 'H'
  localparam logic [7:0] CMD_LIGHT_0   = 8'h30; // '0'
  localparam logic [7:0] CMD_LIGHT_1   = 8'h31;
  localparam logic [7:0] CMD_LIGHT_2   = 8'h32;
  localparam logic [7:0] CMD_LIGHT_3   = 8'h33;
  localparam logic [7:0] CMD_LIGHT_4   = 8'h34;
  localparam logic [7:0] CMD_LIGHT_5   = 8'h35;
  localparam logic [7:0] CMD_LIGHT_6   = 8'h36;
  localparam logic [7:0] CMD_LIGHT_7   = 8'h37;
  localparam logic [7:0] CMD_RAW_ALL_S = 8'h72; // 'r'
  localparam logic [7:0] CMD_RAW_ALL_C = 8'h52; // 'R'
  localparam logic [7:0] CMD_RAW_TAG_S = 8'h74; // 't'
  localparam logic [7:0] CMD_RAW_TAG_C = 8'h54; // 'T'

  // default body capacity of one frame
  localparam int BODY_DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_BLINK1 = 2'd2,
    MODE_BLINK2 = 2'd3
  } light_mode_t;

  // result word, lowest bit last in the list
  typedef struct packed {
    logic [4:0]  pad;
    logic        raw_tag_on;
    logic        raw_all_on;
    logic        light2_arm;
    logic        light1_arm;
    light_mode_t light2_mode;
    light_mode_t light1_mode;
    logic        cmd_done;
    logic        hello;
    logic        nak;
  } result_t;

  localparam int OUT_W = $bits(result_t);

endpackage

`default_nettype wire

### rtl/framed_serial_command_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Framed serial command receiver: takes one received byte per request on the in_ stream and
// returns one status word per byte on the out_ stream. 0x02 opens a frame, 0x04 closes it;
// a frame whose body is exactly one byte runs that byte as a command ('0'..'7' light modes
// with arm pulses, 'r'/'R' and 't'/'T' flags, 'H' hello). A body byte beyond BODY_DEPTH
// raises nak and drops the frame. Each byte passes an input register and then a result register,
// which presents its status word on out_; the out_ side can stall the result register. One byte
// is taken every cycle as long as the out_ side keeps up, and while a result waits the input
// register can still take one more byte.

module framed_serial_command_receiver
  import fscr_pkg::*;
#(
  parameter int BODY_DEPTH = BODY_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // [0] nak, [1] hello, [2] cmd_done, [4:3] light1_mode, [6:5] light2_mode,
  // [7] light1_arm, [8] light2_arm, [9] raw_all_on, [10] raw_tag_on, [15:11] zero
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int CNT_W = $clog2(BODY_DEPTH + 1);

  // pipeline registers
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  result_t     out_data_r;

  // receiver state
  logic              in_frame_r,  in_frame_nxt;
  logic [CNT_W-1:0]  body_cnt_r,  body_cnt_nxt;
  logic [7:0]        first_r,     first_nxt;
  light_mode_t       l1_mode_r,   l1_mode_nxt;
  light_mode_t       l2_mode_r,   l2_mode_nxt;
  logic              raw_all_r,   raw_all_nxt;
  logic              raw_tag_r,   raw_tag_nxt;
  result_t           res_nxt;

  logic out_free;
  logic s1_fire;
  logic run_cmd;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // framing, command decode and result
  always_comb begin
    in_frame_nxt = in_frame_r;
    body_cnt_nxt = body_cnt_r;
    first_nxt    = first_r;
    l1_mode_nxt  = l1_mode_r;
    l2_mode_nxt  = l2_mode_r;
    raw_all_nxt  = raw_all_r;
    raw_tag_nxt  = raw_tag_r;
    res_nxt      = '0;
    run_cmd      = 1'b0;

    priority if (s1_byte_r == BYTE_STX) begin
      in_frame_nxt = 1'b1;
      body_cnt_nxt = '0;
    end else if (s1_byte_r == BYTE_EOT) begin
      run_cmd      = in_frame_r && (body_cnt_r == CNT_W'(1));
      in_frame_nxt = 1'b0;
      body_cnt_nxt = '0;
    end else if (in_frame_r) begin
      if (body_cnt_r == CNT_W'(BODY_DEPTH)) begin
        // overflow drops the frame
        res_nxt.nak  = 1'b1;
        in_frame_nxt = 1'b0;
        body_cnt_nxt = '0;
      end else begin
        if (body_cnt_r == '0) begin
          first_nxt = s1_byte_r;
        end
        body_cnt_nxt = body_cnt_r + CNT_W'(1);
      end
    end else begin
      // bytes outside a frame are dropped
    end

    // one-byte commands
    if (run_cmd) begin
      res_nxt.cmd_done = 1'b1;
      unique case (first_r)
        CMD_HELLO:   res_nxt.hello = 1'b1;
        CMD_LIGHT_0: begin
          l1_mode_nxt = MODE_OFF;
          l2_mode_nxt = MODE_OFF;
        end
        CMD_LIGHT_1: begin
          l1_mode_nxt = MODE_ON;
          res_nxt.light1_arm = 1'b1;
        end
        CMD_LIGHT_2: begin
          l2_mode_nxt = MODE_ON;
          res_nxt.light2_arm = 1'b1;
        end
        CMD_LIGHT_3: begin
          l1_mode_nxt = MODE_BLINK1;
          res_nxt.light1_arm = 1'b1;
        end
        CMD_LIGHT_4: begin
          l2_mode_nxt = MODE_BLINK1;
          res_nxt.light2_arm = 1'b1;
        end
        CMD_LIGHT_5: begin
          l1_mode_nxt = MODE_BLINK2;
          res_nxt.light1_arm = 1'b1;
        end
        CMD_LIGHT_6: begin
          l2_mode_nxt = MODE_BLINK2;
          res_nxt.light2_arm = 1'b1;
        end
        CMD_LIGHT_7: begin
          l1_mode_nxt = MODE_BLINK1;
          l2_mode_nxt = MODE_BLINK2;
          res_nxt.light1_arm = 1'b1;
          res_nxt.light2_arm = 1'b1;
        end
        CMD_RAW_ALL_S: raw_all_nxt = 1'b1;
        CMD_RAW_ALL_C: raw_all_nxt = 1'b0;
        CMD_RAW_TAG_S: raw_tag_nxt = 1'b1;
        CMD_RAW_TAG_C: raw_tag_nxt = 1'b0;
        default:       res_nxt.cmd_done = 1'b0;
      endcase
    end

    res_nxt.light1_mode = l1_mode_nxt;
    res_nxt.light2_mode = l2_mode_nxt;
    res_nxt.raw_all_on  = raw_all_nxt;
    res_nxt.raw_tag_on  = raw_tag_nxt;
  end

  // receiver state, advanced once per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      body_cnt_r <= '0;
      l1_mode_r  <= MODE_OFF;
      l2_mode_r  <= MODE_OFF;
      raw_all_r  <= 1'b0;
      raw_tag_r  <= 1'b0;
    end else if (s1_fire) begin
      in_frame_r <= in_frame_nxt;
      body_cnt_r <= body_cnt_nxt;
      l1_mode_r  <= l1_mode_nxt;
      l2_mode_r  <= l2_mode_nxt;
      raw_all_r  <= raw_all_nxt;
      raw_tag_r  <= raw_tag_nxt;
    end
    if (s1_fire) begin
      first_r <= first_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_fire) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/fscr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fscr_checker
  import fscr_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  result_t res;
  logic    out_stall;
  logic    arm1_off;

  assign res       = out_tdata;
  assign out_stall = out_tvalid && !out_tready;
  assign arm1_off  = res.light1_arm && (res.light1_mode == MODE_OFF);

  // a waiting result holds
  `FSCR_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "result not held")
  // overflow never runs a command
  `FSCR_NEVER(a_nak_no_cmd, out_tvalid && res.nak && res.cmd_done, "nak together with cmd_done")
  // hello is only raised by a completed command
  `FSCR_NEVER(a_hello_done, out_tvalid && res.hello && !res.cmd_done, "hello without cmd_done")
  // a light one arm pulse always leaves light one lit
  `FSCR_NEVER(a_arm_mode, out_tvalid && arm1_off, "light one armed while off")
  // with no result waiting the input side is open
  `FSCR_ASSERT(a_ready_idle, !out_tvalid |-> in_tready, "input blocked with no result waiting")

endmodule

bind framed_serial_command_receiver fscr_checker u_fscr_checker (.*);

`default_nettype wire

### tb/tb_framed_serial_command_receiver.sv
`timescale 1ns / 1ps

module tb_framed_serial_command_receiver;
  import fscr_pkg::*;

  localparam int BODY_CAP   = BODY_DEPTH_DEF;
  localparam int QUIET_MAX  = 400;
  localparam int CHUNK_LEN  = 205;
  localparam int NUM_CHUNKS = 5;

  // tracks receiver state and holds the status words still owed by the block
  class receiver_status_board;
    logic        in_frame;
    int          body_count;
    logic [7:0]  first_body;
    light_mode_t light1;
    light_mode_t light2;
    logic        raw_all;
    logic        raw_tag;
    result_t     status_due[$];
    int          errors;
    int          bytes_seen;
    int          cmds_run;
    int          hellos;
    int          naks;
    int          arm_pulses;

    function new();
      in_frame   = 1'b0;
      body_count = 0;
      first_body = '0;
      light1     = MODE_OFF;
      light2     = MODE_OFF;
      raw_all    = 1'b0;
      raw_tag    = 1'b0;
      errors     = 0;
      bytes_seen = 0;
      cmds_run   = 0;
      hellos     = 0;
      naks       = 0;
      arm_pulses = 0;
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    // works out the status word one accepted byte produces
    function void note_byte(logic [7:0] b);
      result_t r;
      r = '0;
      if (b == BYTE_STX) begin
        in_frame   = 1'b1;
        body_count = 0;
      end else if (b == BYTE_EOT) begin
        if (in_frame && body_count == 1) begin
          r.cmd_done = 1'b1;
          case (first_body)
            CMD_HELLO:     r.hello = 1'b1;
            CMD_LIGHT_0: begin
              light1 = MODE_OFF;
              light2 = MODE_OFF;
            end
            CMD_LIGHT_1: begin
              light1 = MODE_ON;
              r.light1_arm = 1'b1;
            end
            CMD_LIGHT_2: begin
              light2 = MODE_ON;
              r.light2_arm = 1'b1;
            end
            CMD_LIGHT_3: begin
              light1 = MODE_BLINK1;
              r.light1_arm = 1'b1;
            end
            CMD_LIGHT_4: begin
              light2 = MODE_BLINK1;
              r.light2_arm = 1'b1;
            end
            CMD_LIGHT_5: begin
              light1 = MODE_BLINK2;
              r.light1_arm = 1'b1;
            end
            CMD_LIGHT_6: begin
              light2 = MODE_BLINK2;
              r.light2_arm = 1'b1;
            end
            CMD_LIGHT_7: begin
              light1 = MODE_BLINK1;
              light2 = MODE_BLINK2;
              r.light1_arm = 1'b1;
              r.light2_arm = 1'b1;
            end
            CMD_RAW_ALL_S: raw_all = 1'b1;
            CMD_RAW_ALL_C: raw_all = 1'b0;
            CMD_RAW_TAG_S: raw_tag = 1'b1;
            CMD_RAW_TAG_C: raw_tag = 1'b0;
            default:       r.cmd_done = 1'b0;
          endcase
        end
        in_frame   = 1'b0;
        body_count = 0;
      end else if (in_frame) begin
        // body full: the byte is dropped and the frame abandoned
        if (body_count >= BODY_CAP) begin
          r.nak      = 1'b1;
          in_frame   = 1'b0;
          body_count = 0;
        end else begin
          if (body_count == 0) first_body = b;
          body_count++;
        end
      end
      r.light1_mode = light1;
      r.light2_mode = light2;
      r.raw_all_on  = raw_all;
      r.raw_tag_on  = raw_tag;
      status_due.push_back(r);
      bytes_seen++;
      if (r.cmd_done) cmds_run++;
      if (r.hello) hellos++;
      if (r.nak) naks++;
      arm_pulses += int'(r.light1_arm) + int'(r.light2_arm);
    endfunction

    function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
      if (act !== exp) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
        errors++;
      end
    endfunction

    // compares one status word from the block with the oldest one owed
    function void check_status(logic [OUT_W-1:0] word);
      result_t act;
      result_t exp;
      act = word;
      if (status_due.size() == 0) begin
        $error("status word %h arrived with none outstanding", word);
        errors++;
        return;
      end
      exp = status_due.pop_front();
      compare_field("nak", 8'(exp.nak), 8'(act.nak));
      compare_field("hello", 8'(exp.hello), 8'(act.hello));
      compare_field("cmd_done", 8'(exp.cmd_done), 8'(act.cmd_done));
      compare_field("light1_mode", 8'(exp.light1_mode), 8'(act.light1_mode));
      compare_field("light2_mode", 8'(exp.light2_mode), 8'(act.light2_mode));
      compare_field("light1_arm", 8'(exp.light1_arm), 8'(act.light1_arm));
      compare_field("light2_arm", 8'(exp.light2_arm), 8'(act.light2_arm));
      compare_field("raw_all_on", 8'(exp.raw_all_on), 8'(act.raw_all_on));
      compare_field("raw_tag_on", 8'(exp.raw_tag_on), 8'(act.raw_tag_on));
      compare_field("pad", 8'(exp.pad), 8'(act.pad));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic [7:0] rx_plan[$];
  int         send_mode = 0;
  int         sink_mode = 0;
  int         quiet_cycles = 0;

  receiver_status_board board = new();

  framed_serial_command_receiver #(
    .BODY_DEPTH(BODY_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // idle cycles before the next request: none, heavy, or occasional
  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // body byte that is neither a start nor an end byte
  function automatic logic [7:0] random_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_STX || b == BYTE_EOT);
    return b;
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 13))
      0:       return CMD_HELLO;
      1:       return CMD_LIGHT_0;
      2:       return CMD_LIGHT_1;
      3:       return CMD_LIGHT_2;
      4:       return CMD_LIGHT_3;
      5:       return CMD_LIGHT_4;
      6:       return CMD_LIGHT_5;
      7:       return CMD_LIGHT_6;
      8:       return CMD_LIGHT_7;
      9:       return CMD_RAW_ALL_S;
      10:      return CMD_RAW_ALL_C;
      11:      return CMD_RAW_TAG_S;
      12:      return CMD_RAW_TAG_C;
      default: return random_body_byte();
    endcase
  endfunction

  // drives every planned byte, one request each
  task automatic send_plan();
    logic [7:0] b;
    int         gap;
    while (rx_plan.size() > 0) begin
      b = rx_plan.pop_front();
      if (board.bytes_seen % 32 == 0) send_mode = $urandom_range(0, 2);
      gap = draw_gap(send_mode);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= b;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      board.note_byte(b);
    end
  endtask

  // sender holds off until every owed status word has come back
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // result side: random stalls, checks each accepted status word
  initial begin : result_sink
    int gap;
    int n;
    n = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (n % 32 == 0) sink_mode = $urandom_range(0, 2);
      gap = draw_gap(sink_mode);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_status(out_tdata);
      n++;
    end
  end

  // stall watchdog: ends the run when no request moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("framed_serial_command_receiver regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // command 7: both lights change, both arm pulses
    rx_plan.push_back(BYTE_STX);
    rx_plan.push_back(CMD_LIGHT_7);
    rx_plan.push_back(BYTE_EOT);
    // end byte outside a frame
    rx_plan.push_back(BYTE_EOT);
    // unknown one-byte command at the top byte value
    rx_plan.push_back(BYTE_STX);
    rx_plan.push_back(8'hff);
    rx_plan.push_back(BYTE_EOT);
    // start byte inside a frame restarts it, then command 0 turns lights off
    rx_plan.push_back(BYTE_STX);
    rx_plan.push_back(8'h00);
    rx_plan.push_back(BYTE_STX);
    rx_plan.push_back(CMD_LIGHT_0);
    rx_plan.push_back(BYTE_EOT);
    // two-byte body runs nothing
    rx_plan.push_back(BYTE_STX);
    rx_plan.push_back(CMD_RAW_ALL_S);
    rx_plan.push_back(CMD_RAW_TAG_S);
    rx_plan.push_back(BYTE_EOT);
    // empty body
    rx_plan.push_back(BYTE_STX);
    rx_plan.push_back(BYTE_EOT);
    // overflow: one byte past a full body
    rx_plan.push_back(BYTE_STX);
    for (int i = 0; i <= BODY_CAP; i++) rx_plan.push_back(i[0] ? 8'haa : 8'h55);
    send_plan();
    hold_until_drained();

    // random part, mostly well-formed frames with random content
    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      while (rx_plan.size() < CHUNK_LEN) begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          rx_plan.push_back(BYTE_STX);
          rx_plan.push_back(pick_command());
          rx_plan.push_back(BYTE_EOT);
        end else if (kind < 65) begin
          len = $urandom_range(2, BODY_CAP);
          rx_plan.push_back(BYTE_STX);
          for (int i = 0; i < len; i++) rx_plan.push_back(random_body_byte());
          rx_plan.push_back(BYTE_EOT);
        end else if (kind < 72) begin
          rx_plan.push_back(BYTE_STX);
          for (int i = 0; i <= BODY_CAP; i++) rx_plan.push_back(random_body_byte());
          if ($urandom_range(0, 1)) rx_plan.push_back(BYTE_EOT);
        end else if (kind < 80) begin
          len = $urandom_range(0, 3);
          rx_plan.push_back(BYTE_STX);
          for (int i = 0; i < len; i++) rx_plan.push_back(random_body_byte());
          rx_plan.push_back(BYTE_STX);
          rx_plan.push_back(pick_command());
          rx_plan.push_back(BYTE_EOT);
        end else if (kind < 85) begin
          rx_plan.push_back(BYTE_STX);
          rx_plan.push_back(BYTE_EOT);
        end else if (kind < 93) begin
          // line noise, any byte value
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) rx_plan.push_back(8'($urandom_range(0, 255)));
        end else begin
          // exactly full body, closes without nak
          rx_plan.push_back(BYTE_STX);
          for (int i = 0; i < BODY_CAP; i++) rx_plan.push_back(random_body_byte());
          rx_plan.push_back(BYTE_EOT);
        end
      end
      send_plan();
      hold_until_drained();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d bytes: %0d commands run, %0d hello, %0d overflow naks",
             board.bytes_seen, board.cmds_run, board.hellos, board.naks);
    $display("light arm pulses seen: %0d", board.arm_pulses);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("framed_serial_command_receiver regression: pass");
    end else begin
      $display("framed_serial_command_receiver regression: fail");
    end
    $finish;
  end

endmodule
